### hdl/rs485_echo_verified_transmitter_assert.svh
// ----------------------------------------------------------------------------
// rs485_echo_verified_transmitter_assert.svh
// Assertion macros shared by the checker of the echo verified transmitter
// ----------------------------------------------------------------------------
`ifndef RS485_ECHO_VERIFIED_TRANSMITTER_ASSERT_SVH
`define RS485_ECHO_VERIFIED_TRANSMITTER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define R485EVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("r485evt check failed: same-cycle implication");

// next-cycle implication, sampled on aclk, off during reset
`define R485EVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("r485evt check failed: next-cycle implication");

`endif

### hdl/r485evt_pkg.sv
// ----------------------------------------------------------------------------
// r485evt_pkg
// Types, codes and packing shared by the echo verified transmitter
// ----------------------------------------------------------------------------
package r485evt_pkg;

    localparam int DEFAULT_PACKET_DEPTH = 256;

    // event codes carried in the mode field
    localparam logic [2:0] MODE_LOAD     = 3'd0;
    localparam logic [2:0] MODE_TX_READY = 3'd1;
    localparam logic [2:0] MODE_RX_EVENT = 3'd2;
    localparam logic [2:0] MODE_RX_EDGE  = 3'd3;
    localparam logic [2:0] MODE_TX_DONE  = 3'd4;
    localparam logic [2:0] MODE_FRAME_TO = 3'd5;
    localparam logic [2:0] MODE_IDLE_TO  = 3'd6;
    localparam logic [2:0] MODE_NOP      = 3'd7;

    // end of transmission status
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RX_ERROR = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

    localparam int IN_USER_W = 5;
    localparam int OUT_W     = 32;

    // bit positions of the result word
    localparam int BIT_SEND_VALID    = 0;
    localparam int BIT_FORWARD_VALID = 9;
    localparam int BIT_TX_FINISHED   = 18;
    localparam int BIT_TRANSMITTING  = 25;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       forward_valid;
        logic [7:0] forward_byte;
        logic       tx_finished;
        logic [1:0] tx_status;
        logic       frame_discard;
        logic       rx_timer_restart;
        logic       line_busy;
        logic       receiving;
        logic       transmitting;
        logic       driver_enable;
    } result_t;

    function automatic logic [OUT_W-1:0] pack_result(input result_t r);
        pack_result = {5'b0, r.driver_enable, r.transmitting, r.receiving, r.line_busy,
                       r.rx_timer_restart, r.frame_discard, r.tx_status, r.tx_finished,
                       r.forward_byte, r.forward_valid, r.send_byte, r.send_valid};
    endfunction

endpackage

### hdl/r485evt_store.sv
// ----------------------------------------------------------------------------
// r485evt_store
// Packet byte store: one write port, two registered read ports with bypass
// ----------------------------------------------------------------------------
module r485evt_store
    import r485evt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_PACKET_DEPTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [7:0]               rd_data_a,
    output logic [7:0]               rd_data_b
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // a write to the address being read shows up at once
        rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
        rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### hdl/r485evt_ctrl.sv
// ----------------------------------------------------------------------------
// r485evt_ctrl
// Link state and per-event decision logic; one event per accepted word
// ----------------------------------------------------------------------------
module r485evt_ctrl
    import r485evt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_PACKET_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [2:0]               mode,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    input  logic                     rx_error,
    input  logic                     rx_has_data,
    input  logic [7:0]               send_data,
    input  logic [7:0]               echo_data,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [7:0]               wr_data,
    output logic [$clog2(DEPTH)-1:0] send_addr,
    output logic [$clog2(DEPTH)-1:0] echo_addr,
    output result_t                  res
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    logic [PW-1:0] load_count_reg,    load_count_next;
    logic [PW-1:0] packet_length_reg, packet_length_next;
    logic [PW-1:0] send_position_reg, send_position_next;
    logic [PW-1:0] echo_position_reg, echo_position_next;
    logic sending_reg,  sending_next;
    logic pending_reg,  pending_next;
    logic frame_reg,    frame_next;
    logic busy_reg,     busy_next;
    logic edge_reg,     edge_next;
    logic driver_reg,   driver_next;

    always_comb begin
        logic [PW-1:0] cnt;
        logic [PW-1:0] ep1;
        logic          sending;
        logic          do_begin;

        load_count_next    = load_count_reg;
        packet_length_next = packet_length_reg;
        send_position_next = send_position_reg;
        echo_position_next = echo_position_reg;
        sending_next       = sending_reg;
        pending_next       = pending_reg;
        frame_next         = frame_reg;
        busy_next          = busy_reg;
        edge_next          = edge_reg;
        driver_next        = driver_reg;
        wr_en              = 1'b0;
        wr_addr            = load_count_reg[AW-1:0];
        wr_data            = data_byte;
        res                = '0;
        cnt                = load_count_reg;
        ep1                = echo_position_reg + 1'b1;
        sending            = sending_reg;
        do_begin           = 1'b0;

        if (accept) begin
            unique case (mode)
                MODE_LOAD: begin
                    if (!sending_reg && !pending_reg) begin
                        // a full store drops the byte but still honors the last mark
                        if (load_count_reg < PW'(DEPTH)) begin
                            wr_en = 1'b1;
                            cnt   = load_count_reg + 1'b1;
                        end
                        load_count_next = cnt;
                        if (last_byte) begin
                            packet_length_next = cnt;
                            load_count_next    = '0;
                            if (frame_reg) begin
                                pending_next = 1'b1;
                            end else begin
                                do_begin = 1'b1;
                            end
                        end
                    end
                end
                MODE_TX_READY: begin
                    if (sending_reg && (send_position_reg < packet_length_reg)) begin
                        res.send_valid     = 1'b1;
                        res.send_byte      = send_data;
                        send_position_next = send_position_reg + 1'b1;
                    end
                end
                MODE_RX_EVENT: begin
                    if (!sending_reg) begin
                        res.rx_timer_restart = 1'b1;
                        frame_next           = 1'b1;
                        busy_next            = 1'b1;
                    end
                    if (rx_error && sending) begin
                        sending_next  = 1'b0;
                        edge_next     = 1'b1;
                        res.tx_finished = 1'b1;
                        res.tx_status   = STATUS_RX_ERROR;
                        sending       = 1'b0;
                    end
                    if (rx_has_data) begin
                        if (sending) begin
                            echo_position_next = ep1;
                            if (data_byte != echo_data) begin
                                sending_next    = 1'b0;
                                edge_next       = 1'b1;
                                res.tx_finished = 1'b1;
                                res.tx_status   = STATUS_MISMATCH;
                            end else if (ep1 >= packet_length_reg) begin
                                sending_next    = 1'b0;
                                edge_next       = 1'b1;
                                res.tx_finished = 1'b1;
                                res.tx_status   = STATUS_OK;
                            end
                        end else begin
                            res.forward_valid = 1'b1;
                            res.forward_byte  = data_byte;
                        end
                    end
                end
                MODE_RX_EDGE: begin
                    if (edge_reg) begin
                        if (!sending_reg) begin
                            res.rx_timer_restart = 1'b1;
                            frame_next           = 1'b1;
                            busy_next            = 1'b1;
                        end
                        edge_next = 1'b0;
                    end
                end
                MODE_TX_DONE: begin
                    driver_next = 1'b0;
                    if (sending_reg) begin
                        sending_next    = 1'b0;
                        edge_next       = 1'b1;
                        res.tx_finished = 1'b1;
                        res.tx_status   = STATUS_TIMEOUT;
                    end
                end
                MODE_FRAME_TO: begin
                    res.frame_discard = 1'b1;
                    frame_next        = 1'b0;
                    edge_next         = 1'b1;
                    if (pending_reg) begin
                        do_begin = 1'b1;
                    end
                end
                MODE_IDLE_TO: begin
                    busy_next = 1'b0;
                end
                MODE_NOP: begin
                end
            endcase
        end

        // start of a verified transmission
        if (do_begin) begin
            pending_next       = 1'b0;
            edge_next          = 1'b0;
            driver_next        = 1'b1;
            busy_next          = 1'b0;
            send_position_next = '0;
            echo_position_next = '0;
            sending_next       = 1'b1;
        end

        res.line_busy     = busy_next;
        res.receiving     = frame_next;
        res.transmitting  = sending_next;
        res.driver_enable = driver_next;
    end

    // read addresses follow the next positions so the registered read data matches the position registers
    assign send_addr = send_position_next[AW-1:0];
    assign echo_addr = echo_position_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg    <= '0;
            packet_length_reg <= '0;
            send_position_reg <= '0;
            echo_position_reg <= '0;
            sending_reg       <= 1'b0;
            pending_reg       <= 1'b0;
            frame_reg         <= 1'b0;
            busy_reg          <= 1'b0;
            edge_reg          <= 1'b1;
            driver_reg        <= 1'b0;
        end else begin
            load_count_reg    <= load_count_next;
            packet_length_reg <= packet_length_next;
            send_position_reg <= send_position_next;
            echo_position_reg <= echo_position_next;
            sending_reg       <= sending_next;
            pending_reg       <= pending_next;
            frame_reg         <= frame_next;
            busy_reg          <= busy_next;
            edge_reg          <= edge_next;
            driver_reg        <= driver_next;
        end
    end

endmodule

### hdl/rs485_echo_verified_transmitter.sv
// ----------------------------------------------------------------------------
// rs485_echo_verified_transmitter
// Half-duplex RS485 link control with collision detection by echo readback
//
//   channel   dir   word content                                   tlast      tuser
//   s_*       in    data_byte                                      last_byte  mode, rx_error,
//                                                                             rx_has_data
//   m_*       out   send, forward, status and link flags           -          -
//
// One event per cycle when not stalled; each accepted word gives its result next cycle.
// The packet store reads both positions ahead, so a byte is ready without a wait.
// Reset initializes all link state; the packet store is not cleared.
// A result word held by a low m_tready keeps s_tready low until m_tready rises.
// ----------------------------------------------------------------------------
module rs485_echo_verified_transmitter
    import r485evt_pkg::*;
#(
    parameter int PACKET_DEPTH = DEFAULT_PACKET_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // last_byte
    input  logic [IN_USER_W-1:0] s_tuser,   // [2:0] mode, [3] rx_error, [4] rx_has_data
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] send_valid, [8:1] send_byte, [9] forward_valid, [17:10] forward_byte,
    // [18] tx_finished, [20:19] tx_status, [21] frame_discard, [22] rx_timer_restart,
    // [23] line_busy, [24] receiving, [25] transmitting, [26] driver_enable, rest zero
    output logic [OUT_W-1:0]     m_tdata
);

    localparam int AW = $clog2(PACKET_DEPTH);

    logic           accept;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic [AW-1:0]  send_addr;
    logic [AW-1:0]  echo_addr;
    logic [7:0]     send_data;
    logic [7:0]     echo_data;
    result_t        res;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    r485evt_store #(
        .DEPTH(PACKET_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (send_addr),
        .rd_addr_b (echo_addr),
        .rd_data_a (send_data),
        .rd_data_b (echo_data)
    );

    r485evt_ctrl #(
        .DEPTH(PACKET_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .mode        (s_tuser[2:0]),
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .rx_error    (s_tuser[3]),
        .rx_has_data (s_tuser[4]),
        .send_data   (send_data),
        .echo_data   (echo_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .send_addr   (send_addr),
        .echo_addr   (echo_addr),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= pack_result(res);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/r485evt_checker.sv
// ----------------------------------------------------------------------------
// r485evt_checker
// Port-level checks of the echo verified transmitter, bound to the top level
// ----------------------------------------------------------------------------
`include "rs485_echo_verified_transmitter_assert.svh"

module r485evt_checker
    import r485evt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // every accepted word shows up as a result word in the next cycle
    `R485EVT_ASSERT_NEXT(a_accept_gives_word, s_tvalid && s_tready, m_tvalid)

    // stalled result word holds
    `R485EVT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a held result word blocks the input side
    `R485EVT_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

    // bytes go to the line only inside a transmission
    `R485EVT_ASSERT_NOW(a_send_in_tx, m_tvalid && m_tdata[BIT_SEND_VALID],
        m_tdata[BIT_TRANSMITTING])

    // a finished transmission or a forwarded byte leaves the link out of transmit
    `R485EVT_ASSERT_NOW(a_end_or_fwd_idle,
        m_tvalid && (m_tdata[BIT_TX_FINISHED] || m_tdata[BIT_FORWARD_VALID]),
        !m_tdata[BIT_TRANSMITTING])

endmodule

bind rs485_echo_verified_transmitter r485evt_checker u_r485evt_checker (.*);
